@@ rtl/lavm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_pkg: shared types for the look-at view matrix block
// Beat layouts of the input and result channels and the normalizer status.
// ----------------------------------------------------------------------------
package lavm_pkg;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] col_0;
    logic signed [31:0] col_1;
    logic signed [31:0] col_2;
    logic signed [31:0] col_3;
    logic               degenerate;
    logic               last;
  } out_beat_t;

  // Mode codes of an input beat
  localparam logic MODE_SET_POS = 1'b0;
  localparam logic MODE_AIM     = 1'b1;

  typedef struct packed {
    logic done;  // one-cycle pulse when a normalization ends
    logic ok;    // vector was nonzero, result is valid
  } norm_st_t;

endpackage : lavm_pkg
`default_nettype wire

@@ rtl/lavm_norm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_norm: sequential 3-vector normalizer
// Scales the vector one bit a cycle, sums squares on one multiplier, takes a
// bit-pair integer square root and divides each component bit-serially.
// ----------------------------------------------------------------------------
module lavm_norm #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [2:0][33:0]     vec_in,
  output logic      [2:0][31:0]     res_out,
  output lavm_pkg::norm_st_t        st
);

  localparam int QW = FRAC_BITS + 3;
  localparam int NW = FRAC_BITS + 33;
  localparam int CW = $clog2(QW + 1);

  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DINIT, N_DIV} nstate_t;

  nstate_t           state_r;
  logic [2:0][32:0]  mag_r;
  logic [2:0]        neg_r;
  logic [32:0]       m_r;
  logic [63:0]       sq_r;
  logic [63:0]       s_r;
  logic [63:0]       rt_r;
  logic [63:0]       bit_r;
  logic [1:0]        idx_r;
  logic [CW-1:0]     cnt_r;
  logic [31:0]       rem_r;
  logic [QW-1:0]     lo_r;
  logic [QW-1:0]     q_r;
  logic [2:0][31:0]  res_r;
  lavm_pkg::norm_st_t st_r;

  logic [2:0][32:0]  abs_in;
  logic [32:0]       max_in;
  logic [63:0]       sqrt_try;
  logic [NW-1:0]     num;
  logic [32:0]       div_try;
  logic              div_ge;
  logic [QW-1:0]     q_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_in[i] = vec_in[i][33] ? 33'(-vec_in[i]) : vec_in[i][32:0];
    end
    max_in = abs_in[0];
    if (abs_in[1] > max_in) max_in = abs_in[1];
    if (abs_in[2] > max_in) max_in = abs_in[2];
  end

  assign sqrt_try = rt_r + bit_r;
  assign num      = (NW'(mag_r[idx_r]) << FRAC_BITS) + NW'(rt_r[31:1]);
  assign div_try  = {rem_r, lo_r[QW-1]};
  assign div_ge   = div_try >= {1'b0, rt_r[31:0]};
  assign q_nxt    = {q_r[QW-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      st_r    <= '0;
    end else begin
      st_r.done <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            mag_r <= abs_in;
            for (int i = 0; i < 3; i++) neg_r[i] <= vec_in[i][33];
            m_r <= max_in;
            if (max_in == '0) begin
              st_r <= '{done: 1'b1, ok: 1'b0};
            end else begin
              state_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (m_r < 33'(64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
            m_r <= m_r << 1;
          end else if (m_r > 33'(64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
            m_r <= m_r >> 1;
          end else begin
            state_r <= N_SQ;
            idx_r   <= '0;
            s_r     <= '0;
          end
        end
        N_SQ: begin
          // multiply one component while the previous square is added
          if (idx_r != 2'd0) s_r <= s_r + sq_r;
          if (idx_r != 2'd3) begin
            sq_r  <= 64'(mag_r[idx_r][31:0]) * 64'(mag_r[idx_r][31:0]);
            idx_r <= idx_r + 2'd1;
          end else begin
            state_r <= N_SQRT;
            rt_r    <= '0;
            bit_r   <= 64'd1 << 62;
          end
        end
        N_SQRT: begin
          if (s_r >= sqrt_try) begin
            s_r  <= s_r - sqrt_try;
            rt_r <= (rt_r >> 1) + bit_r;
          end else begin
            rt_r <= rt_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 64'd1) begin
            state_r <= N_DINIT;
            idx_r   <= '0;
          end
        end
        N_DINIT: begin
          rem_r   <= 32'(num >> QW);
          lo_r    <= num[QW-1:0];
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= N_DIV;
        end
        N_DIV: begin
          rem_r <= div_ge ? 32'(div_try - {1'b0, rt_r[31:0]}) : div_try[31:0];
          lo_r  <= lo_r << 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(QW - 1)) begin
            res_r[idx_r] <= neg_r[idx_r] ? -32'(q_nxt) : 32'(q_nxt);
            if (idx_r == 2'd2) begin
              st_r    <= '{done: 1'b1, ok: 1'b1};
              state_r <= N_IDLE;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= N_DINIT;
            end
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign res_out = res_r;
  assign st      = st_r;

endmodule : lavm_norm
`default_nettype wire

@@ rtl/look_at_view_matrix.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix: camera view matrix from position and look-at target
// Flow: a position beat takes one pass through the shared normalizer and an
//   aim beat two (up to 30 scaling shifts, 4 square steps, 32-step square
//   root, 3 x (FRAC_BITS+4) divide steps each), followed by the product sums.
//   A forward along the up axis ends the right-vector pass at once.
// Throughput: one input beat per matrix, taken the cycle after the last row
//   leaves; rows leave one per cycle unstalled.
// Reset: position (0,0,0), forward (0,0,1.0), block idle and ready.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lavm_pkg::in_beat_t  in_beat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lavm_pkg::out_beat_t      out_beat
);

  localparam logic [31:0] ONE  = 32'(64'd1 << FRAC_BITS);
  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT_FWD, S_START_RGT, S_WAIT_RGT, S_MAC, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DST_UP0, DST_UP1, DST_UP2, DST_M30, DST_M31, DST_M32
  } mac_dst_t;

  state_t              state_r;
  logic [2:0][31:0]    pos_r;
  logic [2:0][31:0]    fwd_r;
  logic [2:0][31:0]    rgt_r;
  logic [2:0][31:0]    up_r;
  logic [2:0][31:0]    m3_r;
  logic                degen_r;
  logic                norm_start_r;
  logic [2:0][33:0]    norm_vec_r;
  logic [3:0]          step_r;
  logic                ph_r;
  logic [63:0]         prod_r;
  logic                pneg_r;
  logic signed [63:0]  acc_r;
  logic                out_valid_r;
  lavm_pkg::out_beat_t out_r;

  logic [2:0][31:0]    norm_res;
  lavm_pkg::norm_st_t  norm_st;

  // one shared normalizer for the forward and the right vector
  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (norm_start_r),
    .vec_in  (norm_vec_r),
    .res_out (norm_res),
    .st      (norm_st)
  );

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647)       return 32'h7fff_ffff;
    else if (v < -64'sd2147483648) return 32'h8000_0000;
    else                           return v[31:0];
  endfunction

  function automatic logic [33:0] sx34(input logic [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  // Product schedule: two cross-product terms per up component, then three
  // negated dot-product terms per row-3 entry. Each term is rounded alone.
  logic [31:0] op_a, op_b;
  logic        op_sub, op_fin;
  mac_dst_t    op_dst;

  always_comb begin
    op_a = fwd_r[1]; op_b = rgt_r[2]; op_sub = 1'b0; op_fin = 1'b0; op_dst = DST_UP0;
    case (step_r)
      4'd0:  begin op_a = fwd_r[1]; op_b = rgt_r[2]; end
      4'd1:  begin op_a = fwd_r[2]; op_b = rgt_r[1]; op_sub = 1'b1; op_fin = 1'b1; end
      4'd2:  begin op_a = fwd_r[2]; op_b = rgt_r[0]; end
      4'd3:  begin
        op_a = fwd_r[0]; op_b = rgt_r[2]; op_sub = 1'b1; op_fin = 1'b1; op_dst = DST_UP1;
      end
      4'd4:  begin op_a = fwd_r[0]; op_b = rgt_r[1]; end
      4'd5:  begin
        op_a = fwd_r[1]; op_b = rgt_r[0]; op_sub = 1'b1; op_fin = 1'b1; op_dst = DST_UP2;
      end
      4'd6:  begin op_a = rgt_r[0]; op_b = pos_r[0]; op_sub = 1'b1; end
      4'd7:  begin op_a = rgt_r[1]; op_b = pos_r[1]; op_sub = 1'b1; end
      4'd8:  begin
        op_a = rgt_r[2]; op_b = pos_r[2]; op_sub = 1'b1; op_fin = 1'b1; op_dst = DST_M30;
      end
      4'd9:  begin op_a = up_r[0]; op_b = pos_r[0]; op_sub = 1'b1; end
      4'd10: begin op_a = up_r[1]; op_b = pos_r[1]; op_sub = 1'b1; end
      4'd11: begin
        op_a = up_r[2]; op_b = pos_r[2]; op_sub = 1'b1; op_fin = 1'b1; op_dst = DST_M31;
      end
      4'd12: begin op_a = fwd_r[0]; op_b = pos_r[0]; op_sub = 1'b1; end
      4'd13: begin op_a = fwd_r[1]; op_b = pos_r[1]; op_sub = 1'b1; end
      4'd14: begin
        op_a = fwd_r[2]; op_b = pos_r[2]; op_sub = 1'b1; op_fin = 1'b1; op_dst = DST_M32;
      end
      default: ;
    endcase
  end

  logic [31:0]        mag_a, mag_b;
  logic [63:0]        p_round;
  logic signed [63:0] acc_nxt;

  assign mag_a   = op_a[31] ? -op_a : op_a;
  assign mag_b   = op_b[31] ? -op_b : op_b;
  assign p_round = (prod_r + HALF) >> FRAC_BITS;
  assign acc_nxt = pneg_r ? acc_r - $signed(p_round) : acc_r + $signed(p_round);

  // one result row from the stored vectors
  function automatic lavm_pkg::out_beat_t make_row(
    input logic [1:0] k, input logic [2:0][31:0] r, input logic [2:0][31:0] u,
    input logic [2:0][31:0] f, input logic [2:0][31:0] m3, input logic dg);
    lavm_pkg::out_beat_t b;
    b.row        = k;
    b.degenerate = dg;
    b.last       = (k == 2'd3);
    if (k == 2'd3) begin
      b.col_0 = m3[0]; b.col_1 = m3[1]; b.col_2 = m3[2]; b.col_3 = ONE;
    end else begin
      b.col_0 = r[k]; b.col_1 = u[k]; b.col_2 = f[k]; b.col_3 = '0;
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= '0;
      fwd_r        <= {ONE, 32'd0, 32'd0};
      norm_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
      degen_r      <= 1'b0;
    end else begin
      norm_start_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            degen_r <= 1'b0;
            if (in_beat.mode == lavm_pkg::MODE_SET_POS) begin
              pos_r   <= {in_beat.vec_z, in_beat.vec_y, in_beat.vec_x};
              state_r <= S_START_RGT;
            end else begin
              // aim: normalize target minus position
              norm_vec_r[0] <= sx34(in_beat.vec_x) - sx34(pos_r[0]);
              norm_vec_r[1] <= sx34(in_beat.vec_y) - sx34(pos_r[1]);
              norm_vec_r[2] <= sx34(in_beat.vec_z) - sx34(pos_r[2]);
              norm_start_r  <= 1'b1;
              state_r       <= S_WAIT_FWD;
            end
          end
        end
        S_WAIT_FWD: begin
          if (norm_st.done) begin
            if (norm_st.ok) fwd_r <= norm_res;
            else            degen_r <= 1'b1;  // target on position: keep forward
            state_r <= S_START_RGT;
          end
        end
        S_START_RGT: begin
          // right = normalize(up axis x forward) = normalize(f.z, 0, -f.x)
          norm_vec_r[0] <= sx34(fwd_r[2]);
          norm_vec_r[1] <= '0;
          norm_vec_r[2] <= -sx34(fwd_r[0]);
          norm_start_r  <= 1'b1;
          state_r       <= S_WAIT_RGT;
        end
        S_WAIT_RGT: begin
          if (norm_st.done) begin
            // forward along the up axis: zero right, hence zero up
            if (norm_st.ok) begin
              rgt_r <= norm_res;
            end else begin
              rgt_r   <= '0;
              degen_r <= 1'b1;
            end
            step_r  <= '0;
            ph_r    <= 1'b0;
            acc_r   <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (!ph_r) begin
            prod_r <= 64'(mag_a) * 64'(mag_b);
            pneg_r <= op_a[31] ^ op_b[31] ^ op_sub;
            ph_r   <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            if (op_fin) begin
              acc_r <= '0;
              case (op_dst)
                DST_UP0: up_r[0] <= sat32(acc_nxt);
                DST_UP1: up_r[1] <= sat32(acc_nxt);
                DST_UP2: up_r[2] <= sat32(acc_nxt);
                DST_M30: m3_r[0] <= sat32(acc_nxt);
                DST_M31: m3_r[1] <= sat32(acc_nxt);
                DST_M32: m3_r[2] <= sat32(acc_nxt);
                default: ;
              endcase
            end else begin
              acc_r <= acc_nxt;
            end
            if (step_r == 4'd14) begin
              state_r <= S_EMIT;
            end else begin
              step_r <= step_r + 4'd1;
            end
          end
          if (ph_r && step_r == 4'd14) begin
            out_valid_r <= 1'b1;
            out_r <= make_row(2'd0, rgt_r, up_r, fwd_r, m3_r, degen_r);
          end
        end
        S_EMIT: begin
          // advance one row per taken beat, drop valid after the last
          if (!out_stall) begin
            if (out_r.last) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              out_r <= make_row(out_r.row + 2'd1, rgt_r, up_r, fwd_r, m3_r, degen_r);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule : look_at_view_matrix
`default_nettype wire

@@ rtl/lavm_check.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_check: port-level checks for the look-at view matrix block
// Watches the handshakes and the row order of the result beats.
// ----------------------------------------------------------------------------
module lavm_check (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lavm_pkg::out_beat_t out_beat
);

  // busy right after taking a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a matrix was in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while rows still pending");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_beat.last |=>
      out_valid && out_beat.row == $past(out_beat.row) + 2'd1)
    else $error("rows not emitted in order");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("stalled result beat changed");

endmodule : lavm_check

bind look_at_view_matrix lavm_check u_lavm_check (.*);
`default_nettype wire
